// ----- rtl/core/aiops_pkg.sv -----
// Shared types and constants for the arcade I/O port block with bit shifter.
package aiops_pkg;

   // Access direction codes
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Port numbers
   localparam logic [7:0] PORT_FIXED   = 8'h00;
   localparam logic [7:0] PORT_PLAYER1 = 8'h01;
   localparam logic [7:0] PORT_PLAYER2 = 8'h02;
   localparam logic [7:0] PORT_SHIFT   = 8'h03;
   localparam logic [7:0] PORT_PUSH    = 8'h04;
   localparam logic [7:0] PORT_SOUND2  = 8'h05;

   // Fixed read values
   localparam logic [7:0] FIXED_READ_VALUE = 8'h0E;
   localparam logic [7:0] PLAYER1_BASE     = 8'h08;

   // Shifter geometry
   localparam int unsigned SHIFT_WORD_WIDTH   = 16;
   localparam int unsigned SHIFT_OFFSET_WIDTH = 3;

   // One port access
   typedef struct packed {
      logic       mode;
      logic [7:0] port;
      logic [7:0] write_data;
      logic       coin_button;
      logic       start_one_button;
      logic       start_two_button;
      logic       fire_button;
      logic       left_button;
      logic       right_button;
   } req_type;

   // One access result
   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] sound_group_one;
      logic [7:0] sound_group_two;
      logic       coin_sound_pulse;
   } rsp_type;

endpackage

// ----- rtl/core/arcade_io_ports_with_bit_shifter.sv -----
// Arcade I/O port block: input register, port decode and shifter, result register.
//
// Usage:
//   req channel: one port access per transfer (read or write, port number, write byte
//   and the current button levels). A transfer happens when req_valid is high and
//   req_stall is low.
//   rsp channel: exactly one result per access, in order (read byte, both sound
//   latches after the access, coin sound pulse).
//   csr port: csr_write_enable loads csr_write_data into the DIP switch register.
//   Write it only while no access is in flight.
// Order: an accepted access is captured in the input register; the result register then
//   captures its result, which is presented on rsp_valid.
// Throughput: one access per cycle unless rsp_stall holds a result. Port decode, shifter
//   window and state update: one logic level between the input and result registers.
// Stall: when rsp_stall holds a result, the input register still takes one more access;
//   req_stall rises only when both registers are full and the result is held.
// Reset (synchronous, active high): both registers empty, shifter word and offset,
//   coin history, sound latches and DIP switches cleared to zero.
module arcade_io_ports_with_bit_shifter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aiops_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output aiops_pkg::rsp_type  rsp_payload,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);

   // Input stage
   logic               req_valid_ff, req_valid_in;
   aiops_pkg::req_type req_data_ff,  req_data_in;

   // Result stage
   logic               rsp_valid_ff, rsp_valid_in;
   aiops_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   // Block state
   logic [7:0]                                  dip_ff,      dip_in;
   logic [aiops_pkg::SHIFT_WORD_WIDTH-1:0]      shift_word_ff, shift_word_in;
   logic [aiops_pkg::SHIFT_OFFSET_WIDTH-1:0]    shift_off_ff,  shift_off_in;
   logic                                        coin_seen_ff,  coin_seen_in;
   logic [7:0]                                  sound_one_ff,  sound_one_in;
   logic [7:0]                                  sound_two_ff,  sound_two_in;

   logic                                        rsp_load;
   logic                                        advance;
   logic [7:0]                                  players;
   logic [7:0]                                  read_byte;
   logic                                        pulse;
   logic [aiops_pkg::SHIFT_WORD_WIDTH-1:0]      window_word;
   logic [3:0]                                  window_shift;

   // Handshake: result register frees when empty or taken; input stage drains into it
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_load;
   assign req_stall = req_valid_ff && !rsp_load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Input register next value
   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_data_in  = req_payload;
      end
   end

   // Shifter window: word >> (8 - offset)
   assign window_shift = 4'd8 - {1'b0, shift_off_ff};
   assign window_word  = shift_word_ff >> window_shift;

   // Port decode and state update for the access in the input register
   always_comb begin
      players = {1'b0, req_data_ff.right_button, req_data_ff.left_button,
                 req_data_ff.fire_button, 4'b0000};
      read_byte     = 8'h00;
      pulse         = 1'b0;
      dip_in        = dip_ff;
      shift_word_in = shift_word_ff;
      shift_off_in  = shift_off_ff;
      coin_seen_in  = coin_seen_ff;
      sound_one_in  = sound_one_ff;
      sound_two_in  = sound_two_ff;

      if (advance) begin
         if (req_data_ff.mode == aiops_pkg::MODE_READ) begin
            case (req_data_ff.port)
               aiops_pkg::PORT_FIXED: begin
                  read_byte = aiops_pkg::FIXED_READ_VALUE;
               end
               aiops_pkg::PORT_PLAYER1: begin
                  read_byte = aiops_pkg::PLAYER1_BASE | players
                            | {5'b00000, req_data_ff.start_one_button,
                               req_data_ff.start_two_button, req_data_ff.coin_button};
                  pulse        = req_data_ff.coin_button && !coin_seen_ff;
                  coin_seen_in = req_data_ff.coin_button;
               end
               aiops_pkg::PORT_PLAYER2: begin
                  read_byte = dip_ff | players;
               end
               aiops_pkg::PORT_SHIFT: begin
                  read_byte = window_word[7:0];
               end
               default: begin
                  read_byte = 8'h00;
               end
            endcase
         end else begin
            case (req_data_ff.port)
               aiops_pkg::PORT_PLAYER2: begin
                  shift_off_in = req_data_ff.write_data[aiops_pkg::SHIFT_OFFSET_WIDTH-1:0];
               end
               aiops_pkg::PORT_SHIFT: begin
                  sound_one_in = req_data_ff.write_data;
               end
               aiops_pkg::PORT_PUSH: begin
                  shift_word_in = {req_data_ff.write_data, shift_word_ff[15:8]};
               end
               aiops_pkg::PORT_SOUND2: begin
                  sound_two_in = req_data_ff.write_data;
               end
               default: begin
                  shift_word_in = shift_word_ff;
               end
            endcase
         end
      end

      // DIP register write from the csr port
      if (csr_write_enable) begin
         dip_in = csr_write_data;
      end
   end

   // Result register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in                 = req_valid_ff;
         rsp_data_in.read_data        = read_byte;
         rsp_data_in.sound_group_one  = sound_one_in;
         rsp_data_in.sound_group_two  = sound_two_in;
         rsp_data_in.coin_sound_pulse = pulse;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dip_ff        <= 8'h00;
         shift_word_ff <= '0;
         shift_off_ff  <= '0;
         coin_seen_ff  <= 1'b0;
         sound_one_ff  <= 8'h00;
         sound_two_ff  <= 8'h00;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         dip_ff        <= dip_in;
         shift_word_ff <= shift_word_in;
         shift_off_ff  <= shift_off_in;
         coin_seen_ff  <= coin_seen_in;
         sound_one_ff  <= sound_one_in;
         sound_two_ff  <= sound_two_in;
      end
   end

`ifndef SYNTHESIS
   // A write access never returns read data
   assert property (@(posedge clock) disable iff (reset)
      advance && req_data_ff.mode == aiops_pkg::MODE_WRITE |=> rsp_data_ff.read_data == 8'h00)
      else $error("write access returned nonzero read data");

   // A coin pulse leaves the coin history set
   assert property (@(posedge clock) disable iff (reset)
      advance && pulse |=> coin_seen_ff && rsp_data_ff.coin_sound_pulse)
      else $error("coin pulse without coin history update");

   // Reported sound latches match the latch state after the access
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_data_ff.sound_group_one == sound_one_ff
               && rsp_data_ff.sound_group_two == sound_two_ff)
      else $error("sound groups in result differ from latch state");

   // Input side is held only while a result is pending and stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a held result");
`endif

endmodule
